@@ rtl/uplthr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Upload throttle package
// Shared types and constants for the adaptive-chunk upload throttle.
// ----------------------------------------------------------------------------
package uplthr_pkg;

	localparam int unsigned TIME_W   = 48;
	localparam int unsigned CHUNK_W  = 24;
	localparam int unsigned BW_W     = 32;
	localparam int unsigned SLEEP_W  = 41;
	localparam int unsigned CIDX_W   = 3;
	localparam int unsigned SUM_W    = 49;  // bytes + chunk
	localparam int unsigned DVD_W    = 69;  // (bytes + chunk) * 1e6
	localparam int unsigned TGT_W    = 52;  // unclamped target fits here
	localparam int unsigned DIFF_W   = 54;  // target - elapsed, signed
	localparam int unsigned CNT_W    = 7;

	localparam logic [19:0] USEC_PER_S = 20'd1000000;

	localparam logic [SLEEP_W-1:0] SLEEP_MAX = {1'b0, {(SLEEP_W-1){1'b1}}};
	localparam logic [SLEEP_W-1:0] SLEEP_MIN = {1'b1, {(SLEEP_W-1){1'b0}}};

	// register indexes of the configuration port
	localparam logic [CIDX_W-1:0] REG_BANDWIDTH = 3'd0;
	localparam logic [CIDX_W-1:0] REG_MIN_SLEEP = 3'd1;
	localparam logic [CIDX_W-1:0] REG_MAX_SLEEP = 3'd2;
	localparam logic [CIDX_W-1:0] REG_MIN_CHUNK = 3'd3;
	localparam logic [CIDX_W-1:0] REG_MAX_CHUNK = 3'd4;
	localparam logic [CIDX_W-1:0] REG_DEF_CHUNK = 3'd5;
	localparam logic [CIDX_W-1:0] REG_BUFFER    = 3'd6;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_LOAD  = 8'b0000_0010,
		ST_MUL0  = 8'b0000_0100,
		ST_MUL1  = 8'b0000_1000,
		ST_DIV   = 8'b0001_0000,
		ST_SUB   = 8'b0010_0000,
		ST_ADAPT = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

endpackage

@@ rtl/upload_throttle_adaptive_chunk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive-chunk upload throttle
// Computes the sleep needed to keep an upload at the configured byte rate
// and adapts the chunk size from the resulting sleep.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+---------------------------
//  s_axis    | in        | s_axis_tvalid/tready      | bytes_sent, start, now
//  m_axis    | out       | m_axis_tvalid/tready      | sleep_us, next_chunk
//  cfg       | in        | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// Sequence: one sleep evaluation runs load, two multiply steps, the bit-serial
//   radix-2 restoring divider and subtract. A chunk adaptation adds an adapt
//   step; when a non-default chunk adapts, the sleep is evaluated twice. With
//   zero bandwidth an item skips the arithmetic and goes straight to done.
// Reset: the state goes to idle; other control, config and the current chunk
//   clear to zero; datapath registers have no reset; no clearing pass.
// Stalls: s_axis_tready is high only when idle. A finished result waits in the
//   output register; the next item is accepted meanwhile and only holds in
//   its last state if the previous result has not yet been taken.
// cfg_ready is always high; writes belong in idle time only.
//
module upload_throttle_adaptive_chunk
	import uplthr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [143:0]        s_axis_tdata,   // bytes_sent[47:0], start_time_us[95:48],
	                                            // now_time_us[143:96]

	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [71:0]         m_axis_tdata,   // sleep_us[40:0], next_chunk[64:41],
	                                            // zero[71:65]

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [31:0]         cfg_data
);

	// ---------------------------------------------------------------- config
	logic [BW_W-1:0]    bw_q;
	logic [CHUNK_W-1:0] min_sleep_q, max_sleep_q, min_chunk_q, max_chunk_q;
	logic [CHUNK_W-1:0] def_chunk_q, buffer_q;
	logic [CHUNK_W-1:0] chunk_now_q;
	logic               loaded_q;

	// --------------------------------------------------------------- control
	state_t             state_q;
	logic               pass_q;      // second evaluation with the new chunk
	logic [CNT_W-1:0]   cnt_q;       // divider steps left
	logic               out_valid_q;

	// -------------------------------------------------------------- datapath
	logic [TIME_W-1:0]  bytes_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic [SUM_W-1:0]   n_q;
	logic [DVD_W-1:0]   dq_q;        // dividend in, quotient out
	logic [BW_W-1:0]    rem_q;
	logic               huge_q;      // quotient would overflow: target saturates
	logic [DIFF_W-1:0]  sleep_q;
	logic [71:0]        out_data_q;

	// input fields
	logic [TIME_W-1:0]  in_bytes, in_start, in_now, in_elapsed;
	assign in_bytes = s_axis_tdata[47:0];
	assign in_start = s_axis_tdata[95:48];
	assign in_now   = s_axis_tdata[143:96];
	// an unavailable or stale clock counts as no time gone by
	assign in_elapsed = (in_now == '0 || in_now < in_start) ? '0 : in_now - in_start;

	logic in_acc, out_acc, cfg_acc, out_load;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_acc       = out_valid_q & m_axis_tready;
	assign cfg_acc       = cfg_valid & cfg_ready;
	// output register takes a new result when empty or being drained
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// shared multiplier by 1e6: low 32 bits first, then the top 17 bits
	logic [31:0] mul_a;
	logic [51:0] mul_p;
	assign mul_a = (state_q == ST_MUL0) ? n_q[31:0] : {15'b0, n_q[SUM_W-1:32]};
	assign mul_p = {20'b0, mul_a} * {32'b0, USEC_PER_S};

	// one restoring divider step
	logic [BW_W:0]  div_try;
	logic [BW_W:0]  div_diff;
	logic           div_bit;
	assign div_try  = {rem_q, dq_q[DVD_W-1]};
	assign div_diff = div_try - {1'b0, bw_q};
	assign div_bit  = (div_try >= {1'b0, bw_q});

	// chunk adaptation
	logic               sleep_lt_min, sleep_gt_max;
	logic [CHUNK_W:0]   grow_sum, shrink_sum;
	logic [CHUNK_W-1:0] chunk_pick, chunk_new;
	assign sleep_lt_min = !huge_q && ($signed(sleep_q) < $signed({30'b0, min_sleep_q}));
	assign sleep_gt_max = huge_q || ($signed(sleep_q) > $signed({30'b0, max_sleep_q}));
	assign grow_sum     = {1'b0, max_chunk_q} + {1'b0, chunk_now_q};
	assign shrink_sum   = {1'b0, min_chunk_q} + {1'b0, chunk_now_q};

	always_comb begin
		if (sleep_lt_min) begin
			chunk_pick = grow_sum[CHUNK_W:1];
		end else if (sleep_gt_max) begin
			chunk_pick = shrink_sum[CHUNK_W:1];
		end else begin
			chunk_pick = def_chunk_q;
		end
		chunk_new = (chunk_pick == '0 || chunk_pick > buffer_q) ? def_chunk_q : chunk_pick;
	end

	// saturate the signed difference into the output range
	logic [SLEEP_W-1:0] sleep_sat;
	always_comb begin
		if (huge_q) begin
			sleep_sat = SLEEP_MAX;
		end else if (sleep_q[DIFF_W-1:SLEEP_W-1] == '0
				|| sleep_q[DIFF_W-1:SLEEP_W-1] == '1) begin
			sleep_sat = sleep_q[SLEEP_W-1:0];
		end else if (sleep_q[DIFF_W-1]) begin
			sleep_sat = SLEEP_MIN;
		end else begin
			sleep_sat = SLEEP_MAX;
		end
	end

	logic adapt_go;
	assign adapt_go = !pass_q && (bytes_q > {24'b0, chunk_now_q});

	// ------------------------------------------------- control and config regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			loaded_q    <= 1'b0;
			chunk_now_q <= '0;
			bw_q        <= '0;
			min_sleep_q <= '0;
			max_sleep_q <= '0;
			min_chunk_q <= '0;
			max_chunk_q <= '0;
			def_chunk_q <= '0;
			buffer_q    <= '0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_BANDWIDTH: bw_q <= cfg_data;
					REG_MIN_SLEEP: min_sleep_q <= cfg_data[CHUNK_W-1:0];
					REG_MAX_SLEEP: max_sleep_q <= cfg_data[CHUNK_W-1:0];
					REG_MIN_CHUNK: min_chunk_q <= cfg_data[CHUNK_W-1:0];
					REG_MAX_CHUNK: max_chunk_q <= cfg_data[CHUNK_W-1:0];
					REG_DEF_CHUNK: begin
						def_chunk_q <= cfg_data[CHUNK_W-1:0];
						// before the first request the chunk follows the default
						if (!loaded_q) begin
							chunk_now_q <= cfg_data[CHUNK_W-1:0];
						end
					end
					REG_BUFFER:    buffer_q <= cfg_data[CHUNK_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						loaded_q <= 1'b1;
						pass_q   <= 1'b0;
						state_q  <= (bw_q != '0) ? ST_LOAD : ST_DONE;
					end
				end
				ST_LOAD: state_q <= ST_MUL0;
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: begin
					cnt_q   <= CNT_W'(DVD_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SUB;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_SUB: state_q <= adapt_go ? ST_ADAPT : ST_DONE;
				ST_ADAPT: begin
					chunk_now_q <= chunk_new;
					if (chunk_now_q != def_chunk_q) begin
						pass_q  <= 1'b1;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------- datapath regs
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					bytes_q   <= in_bytes;
					elapsed_q <= in_elapsed;
					sleep_q   <= '0;
					huge_q    <= 1'b0;
				end
			end
			ST_LOAD: n_q <= {1'b0, bytes_q} + {25'b0, chunk_now_q};
			ST_MUL0: begin
				dq_q   <= {17'b0, mul_p};
				rem_q  <= '0;
				huge_q <= ({15'b0, n_q} >= {bw_q, 32'b0});
			end
			ST_MUL1: dq_q <= dq_q + {mul_p[36:0], 32'b0};
			ST_DIV: begin
				rem_q <= div_bit ? div_diff[BW_W-1:0] : div_try[BW_W-1:0];
				dq_q  <= {dq_q[DVD_W-2:0], div_bit};
			end
			ST_SUB: sleep_q <= {2'b0, dq_q[TGT_W-1:0]} - {6'b0, elapsed_q};
			ST_DONE: begin
				if (out_load) begin
					out_data_q <= {7'b0, chunk_now_q, sleep_sat};
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	// a result only appears from the final state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside final state");

	// the partial remainder always stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < bw_q)
		else $error("divider remainder out of range");

	// an adapted chunk is the default or a usable size
	a_chunk_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADAPT |=> (chunk_now_q == def_chunk_q
			|| (chunk_now_q != '0 && chunk_now_q <= buffer_q)))
		else $error("adapted chunk out of range");

	// zero bandwidth skips the arithmetic entirely
	a_bw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && bw_q == '0 |=> state_q == ST_DONE)
		else $error("zero bandwidth item entered the datapath");
`endif

endmodule

@@ tb/tb_upload_throttle_adaptive_chunk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive-chunk upload throttle testbench
// Sends throttle requests and configuration writes to the block, predicts each
// sleep and next chunk with a local model of the throttle, and compares every
// result field by field. The run is a directed part followed by random phases
// under several register settings and handshake stall patterns.
// ----------------------------------------------------------------------------
module tb_upload_throttle_adaptive_chunk;
	import uplthr_pkg::*;

	localparam int CLK_HALF       = 2;
	localparam int RST_CYCLES     = 5;
	localparam int WATCHDOG_LIMIT = 5000;   // cycles without any handshake
	localparam int DRAIN_TAIL     = 300;    // two sleep evaluations plus margin
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 141;

	// no register behind this index; writes to it must be dropped
	localparam logic [CIDX_W-1:0] REG_UNUSED = 3'd7;

	localparam longint unsigned TIME_MASK  = (64'd1 << TIME_W) - 64'd1;
	localparam longint unsigned QUOT_LIMIT = 64'h1_0000_0000;
	localparam longint unsigned TARGET_CAP = 64'h4000_0000_0000_0000;
	localparam longint          SLEEP_HI   = (64'sd1 <<< (SLEEP_W - 1)) - 64'sd1;
	localparam longint          SLEEP_LO   = -(64'sd1 <<< (SLEEP_W - 1));

	// where a crafted request should land relative to the sleep window
	typedef enum int {AIM_GROW, AIM_SHRINK, AIM_STEADY, AIM_ANY} aim_t;
	// how bytes_sent relates to the current chunk
	typedef enum int {BYTES_ABOVE, BYTES_WIDE, BYTES_BELOW} span_t;

	// packed so that bytes sits in the low bits, as on s_axis_tdata
	typedef struct packed {
		logic [TIME_W-1:0] now_us;
		logic [TIME_W-1:0] start_us;
		logic [TIME_W-1:0] bytes;
	} req_t;

	typedef struct packed {
		logic [6:0]         pad;
		logic [CHUNK_W-1:0] chunk;
		logic [SLEEP_W-1:0] sleep_us;
	} res_t;

	logic               clk;
	logic               arst_n        = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [143:0]       s_axis_tdata  = '0;  // bytes_sent, start_time_us, now_time_us
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [71:0]        m_axis_tdata;        // sleep_us, next_chunk, zero
	logic               cfg_valid     = 1'b0;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index     = '0;
	logic [31:0]        cfg_data      = '0;

	// shadow of the register file and the chunk state
	logic [BW_W-1:0]    bw_cfg        = '0;
	logic [CHUNK_W-1:0] min_sleep_cfg = '0;
	logic [CHUNK_W-1:0] max_sleep_cfg = '0;
	logic [CHUNK_W-1:0] min_chunk_cfg = '0;
	logic [CHUNK_W-1:0] max_chunk_cfg = '0;
	logic [CHUNK_W-1:0] def_chunk_cfg = '0;
	logic [CHUNK_W-1:0] buf_cfg       = '0;
	logic [CHUNK_W-1:0] chunk_cur     = '0;
	logic               chunk_loaded  = 1'b0;

	res_t pending_res[$];   // predicted results, oldest first
	res_t got_res;
	res_t want_res;
	int   mismatches   = 0;
	int   idle_cycles  = 0;
	int   src_idle_pct = 0;
	int   snk_stall_pct = 0;

	upload_throttle_adaptive_chunk dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Throttle model
	// ------------------------------------------------------------------------

	// floor(total * 1e6 / bw) in two steps; quotients past 32 bits clamp
	function automatic longint unsigned target_us(longint unsigned total);
		longint unsigned bw;
		longint unsigned q;
		longint unsigned r;
		bw = 64'(bw_cfg);
		q  = total / bw;
		r  = total % bw;
		if (q >= QUOT_LIMIT)
			return TARGET_CAP;
		return q * 64'(USEC_PER_S) + (r * 64'(USEC_PER_S)) / bw;
	endfunction

	// exact signed sleep, before saturation
	function automatic longint sleep_for(logic [TIME_W-1:0] bytes,
			logic [CHUNK_W-1:0] chunk, longint unsigned elapsed);
		return longint'(target_us(64'(bytes) + 64'(chunk))) - longint'(elapsed);
	endfunction

	function automatic void apply_reg(logic [CIDX_W-1:0] idx, logic [31:0] val);
		case (idx)
		REG_BANDWIDTH: bw_cfg        = val;
		REG_MIN_SLEEP: min_sleep_cfg = val[CHUNK_W-1:0];
		REG_MAX_SLEEP: max_sleep_cfg = val[CHUNK_W-1:0];
		REG_MIN_CHUNK: min_chunk_cfg = val[CHUNK_W-1:0];
		REG_MAX_CHUNK: max_chunk_cfg = val[CHUNK_W-1:0];
		REG_DEF_CHUNK: begin
			def_chunk_cfg = val[CHUNK_W-1:0];
			// before the first request the default also sets the live chunk
			if (!chunk_loaded)
				chunk_cur = val[CHUNK_W-1:0];
		end
		REG_BUFFER:    buf_cfg       = val[CHUNK_W-1:0];
		default: ;
		endcase
	endfunction

	function automatic res_t predict_throttle(req_t rq);
		longint unsigned    now_v;
		longint unsigned    elapsed;
		longint             slp;
		longint             lo_thr;
		longint             hi_thr;
		logic [CHUNK_W-1:0] prev;
		logic [CHUNK_W:0]   nxt;
		res_t               res;
		chunk_loaded = 1'b1;
		slp    = 0;
		lo_thr = longint'(64'(min_sleep_cfg));
		hi_thr = longint'(64'(max_sleep_cfg));
		if (bw_cfg != '0) begin
			prev  = chunk_cur;
			now_v = 64'(rq.now_us);
			// a missing clock reading, or one behind the start, is replaced by the start time
			if (rq.now_us == '0 || rq.now_us < rq.start_us)
				now_v = 64'(rq.start_us);
			elapsed = now_v - 64'(rq.start_us);
			slp = sleep_for(rq.bytes, chunk_cur, elapsed);
			if (64'(rq.bytes) > 64'(chunk_cur)) begin
				if (slp < lo_thr)
					nxt = ({1'b0, max_chunk_cfg} + {1'b0, chunk_cur}) >> 1;
				else if (slp > hi_thr)
					nxt = ({1'b0, min_chunk_cfg} + {1'b0, chunk_cur}) >> 1;
				else
					nxt = {1'b0, def_chunk_cfg};
				// zero or oversized chunk falls back to the default, checked or not
				if (nxt == '0 || nxt > {1'b0, buf_cfg})
					nxt = {1'b0, def_chunk_cfg};
				chunk_cur = nxt[CHUNK_W-1:0];
				if (prev != def_chunk_cfg)
					slp = sleep_for(rq.bytes, chunk_cur, elapsed);
			end
		end
		if (slp > SLEEP_HI)
			slp = SLEEP_HI;
		if (slp < SLEEP_LO)
			slp = SLEEP_LO;
		res.pad      = '0;
		res.chunk    = chunk_cur;
		res.sleep_us = slp[SLEEP_W-1:0];
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// random value of a random bit width, so magnitudes spread evenly
	function automatic longint unsigned rnd_upto(int w);
		longint unsigned v;
		int              k;
		v = {$urandom, $urandom};
		k = $urandom_range(1, w);
		return v & ((64'd1 << k) - 64'd1);
	endfunction

	function automatic req_t mk_req(logic [TIME_W-1:0] bytes, logic [TIME_W-1:0] start,
			logic [TIME_W-1:0] now);
		req_t rq;
		rq.bytes    = bytes;
		rq.start_us = start;
		rq.now_us   = now;
		return rq;
	endfunction

	// Build a request whose first sleep lands where asked, using the shadow
	// chunk; elapsed time is solved back from the target.
	function automatic req_t craft_req(aim_t aim, span_t span);
		req_t            rq;
		longint unsigned bytes;
		longint unsigned tgt;
		longint unsigned elapsed;
		longint unsigned start;
		longint          aim_sleep;
		longint          el_s;
		longint          lo;
		longint          hi;
		lo = longint'(64'(min_sleep_cfg));
		hi = longint'(64'(max_sleep_cfg));
		case (span)
		BYTES_ABOVE: bytes = 64'(chunk_cur) + 64'd1 + rnd_upto(20);
		BYTES_WIDE:  bytes = rnd_upto(TIME_W);
		default:     bytes = rnd_upto(CHUNK_W) % (64'(chunk_cur) + 64'd1);
		endcase
		tgt = (bw_cfg == '0) ? 64'd0 : target_us(bytes + 64'(chunk_cur));
		case (aim)
		AIM_GROW:   aim_sleep = lo - 1 - longint'(rnd_upto(16));
		AIM_SHRINK: aim_sleep = hi + 1 + longint'(rnd_upto(16));
		AIM_STEADY: aim_sleep = (hi >= lo) ? lo + longint'(rnd_upto(24) % (hi - lo + 1)) : lo;
		default:    aim_sleep = longint'(tgt) - longint'(rnd_upto(TIME_W));
		endcase
		el_s = longint'(tgt) - aim_sleep;
		if (el_s < 0)
			el_s = 0;
		else if (el_s > longint'(TIME_MASK))
			el_s = longint'(TIME_MASK);
		elapsed     = el_s;
		start       = rnd_upto(TIME_W) % (TIME_MASK - elapsed + 64'd1);
		rq.bytes    = bytes[TIME_W-1:0];
		rq.start_us = start[TIME_W-1:0];
		rq.now_us   = TIME_W'(start + elapsed);
		// now and then the clock reading is missing or behind the start
		case ($urandom_range(0, 19))
		0: rq.now_us = '0;
		1: if (start != 0) rq.now_us = TIME_W'(rnd_upto(TIME_W) % start);
		default: ;
		endcase
		return rq;
	endfunction

	// One request: optional idle gap, then hold valid until accepted.
	// Valid stays high on return so back-to-back items never drop it.
	task automatic send_req(input req_t rq);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= rq;
		do @(posedge clk); while (!s_axis_tready);
		pending_res.push_back(predict_throttle(rq));
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
	endtask

	// Hold off new items until every outstanding result has been taken.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_res.size() != 0);
	endtask

	// Upper data bits of the narrow registers carry noise that must be dropped.
	task automatic load_settings(input logic [BW_W-1:0] bw,
			input logic [CHUNK_W-1:0] lo_sleep, hi_sleep, lo_chunk, hi_chunk,
			def_chunk, buf_size);
		write_reg(REG_BANDWIDTH, bw);
		write_reg(REG_MIN_SLEEP, {8'($urandom), lo_sleep});
		write_reg(REG_MAX_SLEEP, {8'($urandom), hi_sleep});
		write_reg(REG_MIN_CHUNK, {8'($urandom), lo_chunk});
		write_reg(REG_MAX_CHUNK, {8'($urandom), hi_chunk});
		write_reg(REG_DEF_CHUNK, {8'($urandom), def_chunk});
		write_reg(REG_BUFFER,    {8'($urandom), buf_size});
		if ($urandom_range(0, 1))
			write_reg(REG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Default writes before the first request load the chunk; later ones do
	// not. Bandwidth is still zero, so sleep must read zero throughout.
	task automatic test_default_preload();
		write_reg(REG_DEF_CHUNK, 32'hAB00_0123);
		write_reg(REG_DEF_CHUNK, 32'h0000_00F0);
		cfg_valid <= 1'b0;
		send_req(craft_req(AIM_ANY, BYTES_WIDE));
		drain_results();
		write_reg(REG_DEF_CHUNK, 32'h0000_0777);
		cfg_valid <= 1'b0;
		send_req(craft_req(AIM_ANY, BYTES_WIDE));
	endtask

	// Field extremes at the slowest and fastest rate: clamped quotient,
	// saturation at both ends, missing clock, clock behind start.
	task automatic test_field_extremes();
		drain_results();
		load_settings(32'd1, 24'd0, 24'hFF_FFFF, 24'd0, 24'd0, 24'd0, 24'd0);
		send_req(mk_req('1, '0, '0));
		send_req(mk_req('0, '1, '1));
		send_req(mk_req('0, '1, '0));
		send_req(mk_req(48'd5, 48'd100, 48'd50));
		drain_results();
		load_settings(32'hFFFF_FFFF, 24'd0, 24'hFF_FFFF, 24'd0, 24'd0, 24'd0, 24'd0);
		send_req(mk_req('0, '0, '1));
		send_req(mk_req('1, '1, '1));
		send_req(mk_req(48'd1, 48'd1, 48'd2));
	endtask

	// Chunk adaptation: steady, grow, shrink, buffer overshoot, zero chunk,
	// no adaptation for small byte counts, an oversized default.
	task automatic test_adapt_paths();
		drain_results();
		// one byte per microsecond keeps the target easy to steer
		load_settings(32'd1_000_000, 24'd1000, 24'd5000, 24'd100, 24'd10000, 24'd2000,
			24'd8000);
		send_req(craft_req(AIM_STEADY, BYTES_ABOVE));
		repeat (3) send_req(craft_req(AIM_GROW, BYTES_ABOVE));
		repeat (2) send_req(craft_req(AIM_SHRINK, BYTES_ABOVE));
		send_req(craft_req(AIM_SHRINK, BYTES_BELOW));
		drain_results();
		// steady range with a zero default drives the chunk to zero
		write_reg(REG_DEF_CHUNK, 32'd0);
		cfg_valid <= 1'b0;
		send_req(craft_req(AIM_STEADY, BYTES_ABOVE));
		drain_results();
		// growing from zero toward one halves to zero, so the default wins
		write_reg(REG_DEF_CHUNK, 32'd2000);
		write_reg(REG_MAX_CHUNK, 32'd1);
		cfg_valid <= 1'b0;
		send_req(craft_req(AIM_GROW, BYTES_ABOVE));
		drain_results();
		// default above the buffer is taken unchecked
		write_reg(REG_DEF_CHUNK, 32'd9000);
		write_reg(REG_MAX_CHUNK, 32'h00FF_FFFF);
		write_reg(REG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
		repeat (2) send_req(craft_req(AIM_GROW, BYTES_ABOVE));
	endtask

	// Random phases: each sets new registers and a stall pattern, and
	// pauses once midway until all results are back.
	task automatic test_random_phases();
		int          kind;
		int unsigned mc;
		int unsigned xc;
		int unsigned dc;
		int unsigned ms;
		int          r;
		aim_t        aim;
		span_t       span;
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			kind = p % 4;
			case ((p + p / 4) % 4)
			0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
			1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
			default: begin src_idle_pct = 7; snk_stall_pct = 7; end
			endcase
			case (kind)
			0: begin
				// ordered window and chunk limits, moderate rate
				mc = $urandom_range(1, 4096);
				xc = $urandom_range(mc, 1 << 22);
				dc = $urandom_range(mc, xc);
				ms = $urandom_range(0, 20000);
				load_settings($urandom_range(1000, 50_000_000), 24'(ms),
					24'(ms + $urandom_range(0, 200000)), 24'(mc), 24'(xc), 24'(dc),
					24'($urandom_range(dc, xc)));
			end
			1: load_settings($urandom, 24'($urandom), 24'($urandom), 24'($urandom),
				24'($urandom), 24'($urandom), 24'($urandom));
			2: load_settings('1, '1, '1, '1, '1, '1, '1);
			default: load_settings(32'd1, '0, '0, '0, 24'($urandom), 24'($urandom),
				24'($urandom));
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					drain_results();
				r    = $urandom_range(0, 19);
				span = (r < 15) ? BYTES_ABOVE : (r < 18) ? BYTES_WIDE : BYTES_BELOW;
				r    = $urandom_range(0, 19);
				aim  = (r < 6) ? AIM_GROW : (r < 12) ? AIM_SHRINK : (r < 17) ? AIM_STEADY :
					AIM_ANY;
				send_req(craft_req(aim, span));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);

	// Pre-edge values are sampled here, so drive order does not matter.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_res = m_axis_tdata;
			if (pending_res.size() == 0) begin
				$error("result with nothing pending: sleep_us %0d next_chunk %0d",
					$signed(got_res.sleep_us), got_res.chunk);
				mismatches++;
			end else begin
				want_res = pending_res.pop_front();
				if (got_res.sleep_us !== want_res.sleep_us) begin
					$error("sleep_us: expected %0d, got %0d", $signed(want_res.sleep_us),
						$signed(got_res.sleep_us));
					mismatches++;
				end
				if (got_res.chunk !== want_res.chunk) begin
					$error("next_chunk: expected %0d, got %0d", want_res.chunk,
						got_res.chunk);
					mismatches++;
				end
			end
		end
	end

	// Any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_preload();
		test_field_extremes();
		test_adapt_paths();
		test_random_phases();
		drain_results();
		// let any stray result show up before the verdict
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatches == 0 && pending_res.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
